>>> src/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg: shared types, constants and step decode for the 4x4 inverse
// Micro-step table of the sequencer, command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mi4_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   // step counter layout: 24 minor steps, 6 determinant steps, 64 element steps
   localparam logic [6:0] PC_DET_FIRST = 7'd24;
   localparam logic [6:0] PC_DET_LAST  = 7'd29;
   localparam logic [6:0] PC_ELEM_BASE = 7'd30;

   localparam logic [3:0] MINOR_C_BASE = 4'd6;
   localparam logic [3:0] MINOR_LAST   = 4'd11;

   localparam logic [1:0] LAST_ROW_IDX = 2'd3;

   // column pairs of the minors: (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
   localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] PAIR_B [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   localparam logic [1:0] ELEM_COL [4][3] = '{
      '{2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd3}, '{2'd0, 2'd1, 2'd2}};
   localparam logic [2:0] MINOR_SEL [4][3] = '{
      '{3'd5, 3'd4, 3'd3}, '{3'd5, 3'd2, 3'd1},
      '{3'd4, 3'd2, 3'd0}, '{3'd3, 3'd1, 3'd0}};
   localparam logic [1:0] SRC_ROW [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

   typedef enum logic [1:0] {A_MEM, A_MINOR, A_ACC} a_src_type;
   typedef enum logic [1:0] {B_MEM, B_MINOR, B_RECIP} b_src_type;
   typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB} acc_op_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_ISSUE, ST_WAIT, ST_DIV, ST_DIV_WAIT, ST_EMIT
   } state_type;

   typedef struct packed {
      logic [3:0] rd_a;      // {row, col} for operand A
      logic [3:0] rd_b;      // {row, col} for operand B
      logic [3:0] mn_a;
      logic [3:0] mn_b;
      a_src_type  a_src;
      b_src_type  b_src;
      acc_op_type acc_op;
      logic       neg;
      logic       wr_minor;
      logic [3:0] mn_w;
      logic       wr_det;
      logic       elem;
      logic [1:0] col;
   } uop_type;

   typedef struct packed {
      logic       wr_row;
      logic [1:0] row_idx;
      logic       clr_sat;
      logic       op_start;
      uop_type    uop;
      logic       div_start;
      logic       snap;
      logic [1:0] snap_row;
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_done;
      logic div_done;
   } dp_stat_type;

   function automatic uop_type uop_decode(input logic [6:0] pc);
      uop_type    u;
      logic [3:0] m;
      logic       g;
      logic [2:0] p;
      logic [2:0] dk;
      logic [5:0] e;
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] k;
      u  = '0;
      m  = pc[4:1];
      g  = (m >= MINOR_C_BASE);
      p  = g ? 3'(m - MINOR_C_BASE) : m[2:0];
      dk = 3'(pc - PC_DET_FIRST);
      e  = 6'(pc - PC_ELEM_BASE);
      i  = e[5:4];
      j  = e[3:2];
      k  = e[1:0];
      if (pc < PC_DET_FIRST) begin
         u.a_src = A_MEM;
         u.b_src = B_MEM;
         if (!pc[0]) begin
            u.rd_a   = {g, 1'b0, PAIR_A[p]};
            u.rd_b   = {g, 1'b1, PAIR_B[p]};
            u.acc_op = OP_LOAD;
         end else begin
            u.rd_a     = {g, 1'b1, PAIR_A[p]};
            u.rd_b     = {g, 1'b0, PAIR_B[p]};
            u.acc_op   = OP_SUB;
            u.wr_minor = 1'b1;
            u.mn_w     = m;
         end
      end else if (pc <= PC_DET_LAST) begin
         // det = s0c5 - s1c4 + s2c3 + s3c2 - s4c1 + s5c0
         u.a_src = A_MINOR;
         u.b_src = B_MINOR;
         u.mn_a  = {1'b0, dk};
         u.mn_b  = MINOR_LAST - {1'b0, dk};
         case (dk)
            3'd0:    u.acc_op = OP_LOAD;
            3'd1:    u.acc_op = OP_SUB;
            3'd4:    u.acc_op = OP_SUB;
            default: u.acc_op = OP_ADD;
         endcase
         u.wr_det = (dk == 3'd5);
      end else if (k != 2'd3) begin
         u.a_src = A_MEM;
         u.b_src = B_MINOR;
         u.rd_a  = {SRC_ROW[j], ELEM_COL[i][k]};
         u.mn_b  = {1'b0, MINOR_SEL[i][k]} + (j[1] ? 4'd0 : MINOR_C_BASE);
         case (k)
            2'd0:    u.acc_op = OP_LOAD;
            2'd1:    u.acc_op = OP_SUB;
            default: u.acc_op = OP_ADD;
         endcase
         u.neg = (k == 2'd2) && (i[0] ^ j[0]);
      end else begin
         u.a_src  = A_ACC;
         u.b_src  = B_RECIP;
         u.acc_op = OP_LOAD;
         u.elem   = 1'b1;
         u.col    = j;
      end
      return u;
   endfunction

endpackage

>>> src/mi4_if.sv
// ----------------------------------------------------------------------------
// mi4 channel interfaces
// Row input channel and inverse-row result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mi4_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] col_x;
   logic signed [31:0] col_y;
   logic signed [31:0] col_z;
   logic signed [31:0] col_w;
   modport source (output valid, col_x, col_y, col_z, col_w, input ready);
   modport sink   (input valid, col_x, col_y, col_z, col_w, output ready);
endinterface

interface mi4_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] inv_x;
   logic signed [31:0] inv_y;
   logic signed [31:0] inv_z;
   logic signed [31:0] inv_w;
   logic [1:0]         row_number;
   logic               last_row;
   logic               singular;
   logic               saturated;
   modport source (output valid, inv_x, inv_y, inv_z, inv_w, row_number, last_row,
                   singular, saturated, input ready);
   modport sink   (input valid, inv_x, inv_y, inv_z, inv_w, row_number, last_row,
                   singular, saturated, output ready);
endinterface

>>> src/mi4_mulq.sv
// ----------------------------------------------------------------------------
// mi4_mulq: fixed-point 64x64 multiply, floor and saturate
// Sign-magnitude product built from four 32x32 partial products, one per
// cycle, then scaled down by the fraction bits and clipped to 64 bits.
// ----------------------------------------------------------------------------
module mi4_mulq #(
   parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] result,
   output logic               sat
);

   localparam logic [127:0] REM_MASK = (128'd1 << FRAC_BITS) - 128'd1;
   localparam logic [127:0] NEG_LIM  = 128'd1 << 63;

   logic         busy_ff, busy_in;
   logic         fin_ff, fin_in;
   logic         done_ff;
   logic [1:0]   cnt_ff;
   logic         neg_ff;
   logic [63:0]  ua_ff, ub_ff;
   logic [127:0] prod_ff;
   logic signed [63:0] res_ff, res_in;
   logic         sat_ff, sat_in;

   logic [31:0]  ha, hb;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [1:0]   sh;
   logic [127:0] qf, qn;
   logic         rem_nz;

   always_comb begin
      ha = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      hb = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp = ha * hb;
      sh = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
      case (sh)
         2'd0:    pp_sh = {64'd0, pp};
         2'd1:    pp_sh = {32'd0, pp, 32'd0};
         default: pp_sh = {pp, 64'd0};
      endcase
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (busy_ff && cnt_ff == 2'd3) begin
         busy_in = 1'b0;
         fin_in  = 1'b1;
      end
      if (start) busy_in = 1'b1;

      // floor toward minus infinity on negative products
      qf     = prod_ff >> FRAC_BITS;
      rem_nz = |(prod_ff & REM_MASK);
      qn     = qf + {127'd0, rem_nz};
      if (!neg_ff) begin
         sat_in = |qf[127:63];
         res_in = sat_in ? mi4_pkg::S64_MAX : qf[63:0];
      end else begin
         sat_in = (qn > NEG_LIM);
         res_in = sat_in ? mi4_pkg::S64_MIN : 64'(-qn[63:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= a[63] ^ b[63];
         ua_ff   <= a[63] ? 64'(-a) : a;
         ub_ff   <= b[63] ? 64'(-b) : b;
         prod_ff <= '0;
         cnt_ff  <= 2'd0;
      end else if (busy_ff) begin
         prod_ff <= prod_ff + pp_sh;
         cnt_ff  <= cnt_ff + 2'd1;
      end
      if (fin_ff) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;
   assign sat    = sat_ff;

endmodule

>>> src/mi4_div.sv
// ----------------------------------------------------------------------------
// mi4_div: reciprocal divider
// Restoring divide of 1.0 squared by a nonzero signed determinant, one
// quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module mi4_div #(
   parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] den,
   output logic               done,
   output logic signed [63:0] quot
);

   localparam int NB = 2 * FRAC_BITS + 1;
   localparam int CW = $clog2(NB + 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(NB - 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [63:0]   d_ff;
   logic [64:0]   rem_ff, rem_in, shv;
   logic [NB-1:0] q_ff, q_in;
   logic          neg_ff;
   logic signed [63:0] res_ff;
   logic          ge;

   always_comb begin
      // dividend is a single one at its top bit
      shv    = {rem_ff[63:0], (cnt_ff == '0)};
      ge     = (shv >= {1'b0, d_ff});
      rem_in = ge ? shv - {1'b0, d_ff} : shv;
      q_in   = {q_ff[NB-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff == CNT_LAST;
         if (start)
            busy_ff <= 1'b1;
         else if (busy_ff && cnt_ff == CNT_LAST)
            busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= den[63];
         d_ff   <= den[63] ? 64'(-den) : den;
         rem_ff <= '0;
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         cnt_ff <= cnt_ff + CW'(1);
         if (cnt_ff == CNT_LAST)
            res_ff <= neg_ff ? 64'(-64'(q_in)) : 64'(q_in);
      end
   end

   assign done = done_ff;
   assign quot = res_ff;

endmodule

>>> src/mi4_dp.sv
// ----------------------------------------------------------------------------
// mi4_dp: inverse datapath
// Row memory, minor memory, shared multiplier with saturating accumulator,
// reciprocal divider and the result output register.
// ----------------------------------------------------------------------------
module mi4_dp #(
   parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mi4_pkg::ctrl_cmd_type cmd,
   output mi4_pkg::dp_stat_type  stat,
   input  logic signed [31:0]   col_x,
   input  logic signed [31:0]   col_y,
   input  logic signed [31:0]   col_z,
   input  logic signed [31:0]   col_w,
   output logic signed [31:0]   inv_x,
   output logic signed [31:0]   inv_y,
   output logic signed [31:0]   inv_z,
   output logic signed [31:0]   inv_w,
   output logic [1:0]           row_number,
   output logic                 last_row,
   output logic                 singular,
   output logic                 saturated
);

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   logic [127:0]       row_mem [4];
   logic signed [63:0] minor_mem [12];

   logic [127:0]       rda_ff, rdb_ff;
   logic signed [63:0] mna_ff, mnb_ff;
   mi4_pkg::uop_type   uop_ff;
   logic               launch_ff;

   logic signed [63:0] acc_ff, det_ff, recip_ff;
   logic signed [31:0] work_ff [4];
   logic               sat_ff, clip_ff;
   logic               zero_done_ff;

   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff, out_w_ff;
   logic [1:0]         out_row_ff;
   logic               out_last_ff, out_sing_ff, out_sat_ff;

   logic signed [63:0] a_val, b_val;
   logic               mul_done, mul_sat;
   logic signed [63:0] mul_res;
   logic               div_done;
   logic signed [63:0] div_q;
   logic               det_zero;

   logic signed [64:0] wide;
   logic signed [63:0] sum, fv;
   logic               ov, nov, clip;
   logic signed [31:0] v32;

   function automatic logic signed [63:0] pick(input logic [127:0] w,
                                               input logic [1:0]   c);
      logic [31:0] x;
      case (c)
         2'd0:    x = w[31:0];
         2'd1:    x = w[63:32];
         2'd2:    x = w[95:64];
         default: x = w[127:96];
      endcase
      return {{32{x[31]}}, x};
   endfunction

   assign det_zero = (det_ff == '0);

   always_comb begin
      case (uop_ff.a_src)
         mi4_pkg::A_MEM:   a_val = pick(rda_ff, uop_ff.rd_a[1:0]);
         mi4_pkg::A_MINOR: a_val = mna_ff;
         default:          a_val = acc_ff;
      endcase
      case (uop_ff.b_src)
         mi4_pkg::B_MEM:   b_val = pick(rdb_ff, uop_ff.rd_b[1:0]);
         mi4_pkg::B_MINOR: b_val = mnb_ff;
         default:          b_val = recip_ff;
      endcase

      wide = '0;
      sum  = mul_res;
      ov   = 1'b0;
      case (uop_ff.acc_op)
         mi4_pkg::OP_ADD: wide = {acc_ff[63], acc_ff} + {mul_res[63], mul_res};
         mi4_pkg::OP_SUB: wide = {acc_ff[63], acc_ff} - {mul_res[63], mul_res};
         default:         wide = {mul_res[63], mul_res};
      endcase
      if (uop_ff.acc_op != mi4_pkg::OP_LOAD) begin
         ov  = wide[64] ^ wide[63];
         sum = ov ? (wide[64] ? mi4_pkg::S64_MIN : mi4_pkg::S64_MAX) : wide[63:0];
      end

      // odd cofactor sign; negating the most negative value clips
      nov = 1'b0;
      fv  = sum;
      if (uop_ff.neg) begin
         nov = (sum == mi4_pkg::S64_MIN);
         fv  = nov ? mi4_pkg::S64_MAX : 64'(-sum);
      end

      clip = (fv > S32_MAX) || (fv < S32_MIN);
      if (fv > S32_MAX)
         v32 = S32_MAX[31:0];
      else if (fv < S32_MIN)
         v32 = S32_MIN[31:0];
      else
         v32 = fv[31:0];
   end

   mi4_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
      .clock  (clock),
      .reset  (reset),
      .start  (launch_ff),
      .a      (a_val),
      .b      (b_val),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   mi4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start && !det_zero),
      .den   (det_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // row memory
   always_ff @(posedge clock) begin
      if (cmd.wr_row)
         row_mem[cmd.row_idx] <= {col_w, col_z, col_y, col_x};
      if (cmd.op_start) begin
         rda_ff <= row_mem[cmd.uop.rd_a[3:2]];
         rdb_ff <= row_mem[cmd.uop.rd_b[3:2]];
      end
   end

   // minor memory
   always_ff @(posedge clock) begin
      if (mul_done && uop_ff.wr_minor)
         minor_mem[uop_ff.mn_w] <= fv;
      if (cmd.op_start) begin
         mna_ff <= minor_mem[cmd.uop.mn_a];
         mnb_ff <= minor_mem[cmd.uop.mn_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff    <= 1'b0;
         zero_done_ff <= 1'b0;
         sat_ff       <= 1'b0;
         clip_ff      <= 1'b0;
      end else begin
         launch_ff    <= cmd.op_start;
         zero_done_ff <= cmd.div_start && det_zero;
         if (cmd.clr_sat)
            sat_ff <= 1'b0;
         else if (mul_done)
            sat_ff <= sat_ff | mul_sat | ov | nov;
         if (cmd.snap || cmd.clr_sat)
            clip_ff <= 1'b0;
         else if (mul_done && uop_ff.elem)
            clip_ff <= clip_ff | clip;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_start)
         uop_ff <= cmd.uop;
      if (mul_done) begin
         acc_ff <= fv;
         if (uop_ff.wr_det)
            det_ff <= fv;
         if (uop_ff.elem)
            work_ff[uop_ff.col] <= v32;
      end
      if (zero_done_ff)
         recip_ff <= '0;
      else if (div_done)
         recip_ff <= div_q;
   end

   // result register, parts the work from the result channel
   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         out_x_ff    <= det_zero ? '0 : work_ff[0];
         out_y_ff    <= det_zero ? '0 : work_ff[1];
         out_z_ff    <= det_zero ? '0 : work_ff[2];
         out_w_ff    <= det_zero ? '0 : work_ff[3];
         out_row_ff  <= cmd.snap_row;
         out_last_ff <= (cmd.snap_row == mi4_pkg::LAST_ROW_IDX);
         out_sing_ff <= det_zero;
         out_sat_ff  <= !det_zero && (clip_ff || sat_ff);
      end
   end

   assign stat.op_done  = mul_done;
   assign stat.div_done = div_done || zero_done_ff;

   assign inv_x      = out_x_ff;
   assign inv_y      = out_y_ff;
   assign inv_z      = out_z_ff;
   assign inv_w      = out_w_ff;
   assign row_number = out_row_ff;
   assign last_row   = out_last_ff;
   assign singular   = out_sing_ff;
   assign saturated  = out_sat_ff;

endmodule

>>> src/mi4_ctrl.sv
// ----------------------------------------------------------------------------
// mi4_ctrl: inverse sequencer
// Loads rows, steps through the minor, determinant, reciprocal and element
// steps, and hands finished rows to the result register.
// ----------------------------------------------------------------------------
module mi4_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mi4_pkg::dp_stat_type  stat,
   output mi4_pkg::ctrl_cmd_type cmd
);

   mi4_pkg::state_type state_ff, state_in;
   logic [6:0] pc_ff, pc_in;
   logic [1:0] rows_ff, rows_in;
   logic       out_valid_ff, out_valid_in;
   logic [5:0] e;

   always_comb begin
      e            = 6'(pc_ff - mi4_pkg::PC_ELEM_BASE);
      state_in     = state_ff;
      pc_in        = pc_ff;
      rows_in      = rows_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.uop      = mi4_pkg::uop_decode(pc_ff);
      cmd.row_idx  = rows_ff;
      cmd.snap_row = e[5:4];
      case (state_ff)
         mi4_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_row = 1'b1;
               rows_in    = rows_ff + 2'd1;
               if (rows_ff == mi4_pkg::LAST_ROW_IDX) begin
                  cmd.clr_sat = 1'b1;
                  pc_in       = '0;
                  state_in    = mi4_pkg::ST_ISSUE;
               end
            end
         end
         mi4_pkg::ST_ISSUE: begin
            cmd.op_start = 1'b1;
            state_in     = mi4_pkg::ST_WAIT;
         end
         mi4_pkg::ST_WAIT: begin
            if (stat.op_done) begin
               pc_in = pc_ff + 7'd1;
               if (pc_ff == mi4_pkg::PC_DET_LAST)
                  state_in = mi4_pkg::ST_DIV;
               else if (pc_ff >= mi4_pkg::PC_ELEM_BASE && e[3:0] == 4'hF)
                  state_in = mi4_pkg::ST_EMIT;
               else
                  state_in = mi4_pkg::ST_ISSUE;
            end
         end
         mi4_pkg::ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = mi4_pkg::ST_DIV_WAIT;
         end
         mi4_pkg::ST_DIV_WAIT: begin
            if (stat.div_done)
               state_in = mi4_pkg::ST_ISSUE;
         end
         mi4_pkg::ST_EMIT: begin
            // pc already points past the row's last step
            cmd.snap_row = 2'(e[5:4] - 2'd1);
            if (!out_valid_ff || rsp_ready) begin
               cmd.snap = 1'b1;
               if (cmd.snap_row == mi4_pkg::LAST_ROW_IDX)
                  state_in = mi4_pkg::ST_LOAD;
               else
                  state_in = mi4_pkg::ST_ISSUE;
            end
         end
         default: state_in = mi4_pkg::ST_LOAD;
      endcase

      if (cmd.snap)
         out_valid_in = 1'b1;
      else if (rsp_ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mi4_pkg::ST_LOAD;
         pc_ff        <= '0;
         rows_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rows_ff      <= rows_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> src/matrix_inverse_4x4.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4: cofactor inverse of a 4x4 signed fixed-point matrix
//
//   channel  dir  beat                              per inversion
//   req_if   in   one matrix row, col_x..col_w      4 beats
//   rsp_if   out  one inverse row with flags        4 beats, last_row on 4th
//
// A row beat is taken whenever the sequencer waits for rows. After the
// fourth row the inversion runs 94 multiply steps through the one shared
// 64x64 multiplier (four 32x32 partial products a step), with a pass of
// the bit-serial reciprocal divider between determinant and element steps.
// Reset clears the sequencer and the datapath control flags; the row store needs no clearing.
// A stalled result holds the next row in the datapath until it is taken;
// rows of the next matrix are taken while the last result still waits.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 #(
   parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   mi4_req_if.sink    req_if,
   mi4_rsp_if.source  rsp_if
);

   mi4_pkg::ctrl_cmd_type cmd;
   mi4_pkg::dp_stat_type  stat;

   mi4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mi4_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .col_x      (req_if.col_x),
      .col_y      (req_if.col_y),
      .col_z      (req_if.col_z),
      .col_w      (req_if.col_w),
      .inv_x      (rsp_if.inv_x),
      .inv_y      (rsp_if.inv_y),
      .inv_z      (rsp_if.inv_z),
      .inv_w      (rsp_if.inv_w),
      .row_number (rsp_if.row_number),
      .last_row   (rsp_if.last_row),
      .singular   (rsp_if.singular),
      .saturated  (rsp_if.saturated)
   );

endmodule

>>> bench/mi4_test_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mi4_test_pkg: bench-side constants for the 4x4 inverse bench
// The channel interfaces come with the RTL (src/mi4_if.sv); this package only
// holds the matrix shape that the send_matrix stimulus task uses.
// ----------------------------------------------------------------------------
package mi4_test_pkg;
   localparam int ROWS_PER_MATRIX = 4;
endpackage

>>> bench/matrix_inverse_4x4_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_test: self-checking bench for the 4x4 fixed-point inverse
// Loads matrices row by row, predicts each inverse row with an exact
// saturating Q16.16 cofactor model and checks every result beat in order.
// ----------------------------------------------------------------------------
class inverse_scoreboard;
   typedef struct packed {
      logic signed [31:0] x, y, z, w;
      logic [1:0]         row;
      logic               last, sing, sat;
   } inv_row_type;

   localparam int F = mi4_pkg::FRAC_BITS_DEF;
   logic signed [31:0] mat [16];
   int                 rows_in;
   bit                 sat;
   inv_row_type        pending [$];
   int                 errors, matrices, singulars, saturations;

   function new();
      rows_in = 0; errors = 0; matrices = 0; singulars = 0; saturations = 0;
   endfunction

   function logic signed [63:0] mulq(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] p, q;
      p = 128'(a) * 128'(b);
      q = p >>> F;  // floor
      if (q > 128'sh7FFF_FFFF_FFFF_FFFF) begin
         sat = 1; return mi4_pkg::S64_MAX;
      end
      if (q < -128'sh8000_0000_0000_0000) begin
         sat = 1; return mi4_pkg::S64_MIN;
      end
      return q[63:0];
   endfunction

   function logic signed [63:0] clamp(logic signed [65:0] v);
      if (v > 66'sh7FFF_FFFF_FFFF_FFFF) begin
         sat = 1; return mi4_pkg::S64_MAX;
      end
      if (v < -66'sh8000_0000_0000_0000) begin
         sat = 1; return mi4_pkg::S64_MIN;
      end
      return v[63:0];
   endfunction

   function logic signed [63:0] add(logic signed [63:0] a, logic signed [63:0] b);
      return clamp(66'(a) + 66'(b));
   endfunction

   function logic signed [63:0] sub(logic signed [63:0] a, logic signed [63:0] b);
      return clamp(66'(a) - 66'(b));
   endfunction

   function logic signed [63:0] el(int r, int c);
      return 64'(mat[r*4+c]);
   endfunction

   function logic signed [63:0] minor2(int r0, int r1, int ca, int cb);
      return sub(mulq(el(r0, ca), el(r1, cb)), mulq(el(r1, ca), el(r0, cb)));
   endfunction

   function void note_row(logic signed [31:0] x, y, z, w);
      logic signed [63:0] s [6], c [6], t [3], det, recip, cof, v;
      int                 pa [6], pb [6], ecol [4][3], msel [4][3], srow [4];
      bit                 sing, clip;
      inv_row_type        r;
      logic signed [31:0] e [4];
      pa = '{0,0,0,1,1,2}; pb = '{1,2,3,2,3,3};
      ecol = '{'{1,2,3},'{0,2,3},'{0,1,3},'{0,1,2}};
      msel = '{'{5,4,3},'{5,2,1},'{4,2,0},'{3,1,0}};
      srow = '{1,0,3,2};
      mat[rows_in*4+0] = x; mat[rows_in*4+1] = y;
      mat[rows_in*4+2] = z; mat[rows_in*4+3] = w;
      if (rows_in < 3) begin
         rows_in++;
         return;
      end
      rows_in = 0;
      sat = 0;
      matrices++;
      for (int i = 0; i < 6; i++) s[i] = minor2(0, 1, pa[i], pb[i]);
      for (int i = 0; i < 6; i++) c[i] = minor2(2, 3, pa[i], pb[i]);
      det = mulq(s[0], c[5]);
      det = sub(det, mulq(s[1], c[4]));
      det = add(det, mulq(s[2], c[3]));
      det = add(det, mulq(s[3], c[2]));
      det = sub(det, mulq(s[4], c[1]));
      det = add(det, mulq(s[5], c[0]));
      sing = (det == 0);
      recip = sing ? 64'sd0 : (64'sd1 <<< (2*F)) / det;
      if (sing) singulars++;
      for (int i = 0; i < 4; i++) begin
         clip = 0;
         for (int j = 0; j < 4; j++) begin
            // top two source rows pair with bottom minors, the rest with top ones
            for (int k = 0; k < 3; k++)
               t[k] = mulq(el(srow[j], ecol[i][k]),
                           (j < 2) ? c[msel[i][k]] : s[msel[i][k]]);
            cof = add(sub(t[0], t[1]), t[2]);
            if ((i + j) & 1) cof = sub(0, cof);
            v = mulq(cof, recip);
            if (v > 64'sh7FFF_FFFF) begin
               v = 64'sh7FFF_FFFF; clip = 1;
            end
            if (v < -64'sh8000_0000) begin
               v = -64'sh8000_0000; clip = 1;
            end
            if (sing) v = 0;
            e[j] = v[31:0];
         end
         r = '{e[0], e[1], e[2], e[3], 2'(i), i == 3, sing, !sing && (clip || sat)};
         if (r.sat) saturations++;
         pending.push_back(r);
      end
   endfunction

   function void check_row(inv_row_type got);
      inv_row_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result beat %p", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         $display("%0t: mismatch expected %p actual %p", $time, want, got);
         errors++;
      end
   endfunction
endclass

module matrix_inverse_4x4_test;

   localparam int N_RANDOM_MATS = 36;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   logic clock = 0;
   logic reset = 1;
   mi4_req_if req_if ();
   mi4_rsp_if rsp_if ();
   inverse_scoreboard inv_model = new();
   bit idle_on = 1;
   bit feed_done = 0;

   matrix_inverse_4x4 DUT (.clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if));

   always #5 clock = ~clock;

   initial begin
      req_if.valid <= 0;
      req_if.col_x <= 0; req_if.col_y <= 0; req_if.col_z <= 0; req_if.col_w <= 0;
      rsp_if.ready <= 0;
   end

   // result side: random stall bursts, checked on accept
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         inv_model.check_row({rsp_if.inv_x, rsp_if.inv_y, rsp_if.inv_z, rsp_if.inv_w,
                              rsp_if.row_number, rsp_if.last_row, rsp_if.singular,
                              rsp_if.saturated});
   end

   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         rsp_if.ready <= 1;
         n = $urandom_range(1, 20);
         repeat (n) @(posedge clock);
         if (idle_on && $urandom_range(0, 1)) begin
            rsp_if.ready <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   task automatic send_row(logic signed [31:0] x, y, z, w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.col_x <= x; req_if.col_y <= y; req_if.col_z <= z; req_if.col_w <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      inv_model.note_row(x, y, z, w);
   endtask

   function automatic logic signed [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return 32'($signed($urandom_range(0, 4095)) - 2048);
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   task automatic send_matrix(logic signed [31:0] m [16]);
      for (int r = 0; r < mi4_test_pkg::ROWS_PER_MATRIX; r++)
         send_row(m[r*4], m[r*4+1], m[r*4+2], m[r*4+3]);
   endtask

   initial begin
      logic signed [31:0] m [16];
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // identity, scaled diagonal, all-zero (singular), rank-deficient
      m = '{ONE,0,0,0, 0,ONE,0,0, 0,0,ONE,0, 0,0,0,ONE};
      send_matrix(m);
      m = '{2*ONE,0,0,0, 0,-4*ONE,0,0, 0,0,ONE/2,0, 0,0,0,ONE*3};
      send_matrix(m);
      m = '{default: 0};
      send_matrix(m);
      m = '{ONE,2*ONE,3*ONE,4*ONE, ONE,2*ONE,3*ONE,4*ONE, 5,6,7,8, 9,10,11,12};
      send_matrix(m);
      // extremes: every bit of every field toggles
      m = '{32'sh7FFF_FFFF,32'sh8000_0000,-1,32'sh7FFF_FFFF,
            32'sh8000_0000,32'sh7FFF_FFFF,32'sh5555_5555,32'shAAAA_AAAA,
            -1,32'sh0000_0001,32'sh7FFF_FFFF,32'sh8000_0000,
            32'shAAAA_AAAA,32'sh5555_5555,32'sh8000_0000,32'sh7FFF_FFFF};
      send_matrix(m);
      // tiny diagonal: products floor to zero, so the determinant is zero (singular)
      m = '{1,0,0,0, 0,1,0,0, 0,0,1,0, 0,0,0,1};
      send_matrix(m);
      for (int i = 0; i < N_RANDOM_MATS; i++) begin
         if (i == N_RANDOM_MATS - 8) idle_on = 0;
         if ($urandom_range(0, 3) == 0) begin
            // near-diagonal well-conditioned
            foreach (m[k]) m[k] = (k % 5 == 0) ? ONE * $urandom_range(1, 8)
                                               : 32'($signed($urandom_range(0, 8191)) - 4096);
         end else
            foreach (m[k]) m[k] = rand_elem();
         send_matrix(m);
      end
      req_if.valid <= 0;
      feed_done = 1;
   end

   initial begin
      wait (feed_done);
      while (inv_model.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Inverted %0d matrices: %0d singular, %0d rows flagged saturated.",
               inv_model.matrices, inv_model.singulars, inv_model.saturations);
      if (inv_model.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d rows still expected.", inv_model.pending.size());
      $display("CHECK FAILED");
      $finish;
   end
endmodule
